/* hdl/assert_macros.svh */
// Assertion macros for the stream hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/sha256_pkg.sv */
// Constants, tables and round functions for the SHA-256 stream hasher.
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

/* hdl/sha256_stream_hasher.sv */
// SHA-256 stream hasher: byte intake, padding, compression and digest output.
// Takes one message byte per request that has byte_present set; requests are
// not taken while a block is compressed. Every full 64-byte block runs a
// compression: it reads the block memory into the schedule window and the
// hash memory into the working registers, runs 64 rounds of one round per
// cycle, then adds and writes the chaining value back. At message end the
// padder writes one byte per cycle up to the block end (twice when the length
// does not fit), runs one or two compressions, then presents the eight digest
// words, each read in S_EMIT_RD and held in S_EMIT_OUT until the result side
// takes it. After reset the hash memory is loaded with the initial hash
// before the first request is taken.
`default_nettype none

`include "assert_macros.svh"

module sha256_stream_hasher import sha256_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_ready,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             digest_valid,
  input  wire logic        digest_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PAD, S_LOAD, S_ROUND, S_WBACK, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  state_t      state;
  logic [5:0]  step;
  logic [5:0]  fill;
  logic [60:0] total;
  logic [5:0]  pad_pos;
  logic        pad_mark;
  logic        len_block;
  logic        fin;
  logic        pad_go;

  word_t st [8];
  word_t w  [16];

  word_t block_mem [16];
  word_t hash_mem  [8];
  word_t blk_rd;
  word_t hash_rd;

  logic        blk_we;
  logic [3:0]  blk_waddr;
  logic [1:0]  blk_lane;
  logic [7:0]  blk_wdata;
  logic        blk_re;
  logic        hash_we;
  logic [2:0]  hash_waddr;
  word_t       hash_wdata;
  logic        hash_re;

  logic        accept;
  logic        out_accept;
  logic [5:0]  fill_inc;
  logic [5:0]  pad_start;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;
  word_t       t1;
  word_t       t2;
  word_t       w_new;

  assign msg_ready    = (state == S_IDLE);
  assign digest_valid = (state == S_EMIT_OUT);
  assign accept       = msg_valid && msg_ready;
  assign out_accept   = digest_valid && digest_ready;
  assign digest_word  = hash_rd;
  assign word_index   = step[2:0];
  assign last_word    = (step[2:0] == 3'd7);

  assign fill_inc  = fill + 6'd1;
  assign pad_start = byte_present ? fill_inc : fill;
  assign bit_len   = {total, 3'b000};

  always_comb begin
    if (pad_mark) begin
      pad_byte = PAD_MARK;
    end else if (len_block && pad_pos >= LEN_POS) begin
      pad_byte = bit_len[{~pad_pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign t1 = st[7] + big_sigma1(st[4]) + choose(st[4], st[5], st[6]) +
              ROUND_K[step] + w[0];
  assign t2 = big_sigma0(st[0]) + majority(st[0], st[1], st[2]);
  assign w_new = w[0] + small_sigma0(w[1]) + w[9] + small_sigma1(w[14]);

  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = fill[5:2];
    blk_lane  = fill[1:0];
    blk_wdata = msg_byte;
    if (state == S_IDLE) begin
      blk_we = accept && byte_present;
    end else if (state == S_PAD) begin
      blk_we    = 1'b1;
      blk_waddr = pad_pos[5:2];
      blk_lane  = pad_pos[1:0];
      blk_wdata = pad_byte;
    end
  end

  assign blk_re  = (state == S_LOAD) && (step < 6'd16);
  assign hash_re = ((state == S_LOAD || state == S_WBACK) && step < 6'd8) ||
                   (state == S_EMIT_RD);

  always_comb begin
    hash_we    = 1'b0;
    hash_waddr = step[2:0];
    hash_wdata = INIT_H[step[2:0]];
    case (state)
      S_INIT: begin
        hash_we = 1'b1;
      end
      S_WBACK: begin
        hash_we    = (step != 6'd0);
        hash_waddr = step[2:0] - 3'd1;
        hash_wdata = hash_rd + st[0];
      end
      S_EMIT_OUT: begin
        hash_we = out_accept;
      end
      default: begin
        hash_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      block_mem[blk_waddr][{~blk_lane, 3'b000} +: 8] <= blk_wdata;
    end
    if (blk_re) begin
      blk_rd <= block_mem[step[3:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[hash_waddr] <= hash_wdata;
    end
    if (hash_re) begin
      hash_rd <= hash_mem[step[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      step      <= '0;
      fill      <= '0;
      total     <= '0;
      pad_pos   <= '0;
      pad_mark  <= 1'b0;
      len_block <= 1'b0;
      fin       <= 1'b0;
      pad_go    <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          step <= step + 6'd1;
          if (step == 6'd7) begin
            step  <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (byte_present) begin
              fill  <= fill_inc;
              total <= total + 61'd1;
            end
            if (byte_present && fill == 6'd63) begin
              state     <= S_LOAD;
              step      <= '0;
              fin       <= 1'b0;
              pad_go    <= end_of_message;
              pad_pos   <= '0;
              pad_mark  <= 1'b1;
              len_block <= 1'b1;
            end else if (end_of_message) begin
              state     <= S_PAD;
              pad_pos   <= pad_start;
              pad_mark  <= 1'b1;
              len_block <= (pad_start < LEN_POS);
            end
          end
        end
        S_PAD: begin
          pad_mark <= 1'b0;
          pad_pos  <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            state     <= S_LOAD;
            step      <= '0;
            fin       <= len_block;
            pad_go    <= !len_block;
            len_block <= 1'b1;
          end
        end
        S_LOAD: begin
          if (step != 6'd0) begin
            for (int i = 0; i < 15; i++) begin
              w[i] <= w[i + 1];
            end
            w[15] <= blk_rd;
          end
          if (step != 6'd0 && step <= 6'd8) begin
            for (int i = 0; i < 7; i++) begin
              st[i] <= st[i + 1];
            end
            st[7] <= hash_rd;
          end
          step <= step + 6'd1;
          if (step == 6'd16) begin
            step  <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          st[0] <= t1 + t2;
          st[1] <= st[0];
          st[2] <= st[1];
          st[3] <= st[2];
          st[4] <= st[3] + t1;
          st[5] <= st[4];
          st[6] <= st[5];
          st[7] <= st[6];
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= w_new;
          step  <= step + 6'd1;
          if (step == 6'd63) begin
            step  <= '0;
            state <= S_WBACK;
          end
        end
        S_WBACK: begin
          if (step != 6'd0) begin
            for (int i = 0; i < 7; i++) begin
              st[i] <= st[i + 1];
            end
          end
          step <= step + 6'd1;
          if (step == 6'd8) begin
            step <= '0;
            if (fin) begin
              state <= S_EMIT_RD;
            end else if (pad_go) begin
              state  <= S_PAD;
              pad_go <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_accept) begin
            if (step[2:0] == 3'd7) begin
              state <= S_IDLE;
              step  <= '0;
              fill  <= '0;
              total <= '0;
              fin   <= 1'b0;
            end else begin
              step  <= step + 6'd1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_INIT;
          step  <= '0;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overlap, clk, rst, digest_valid, !msg_ready)
  `ASSERT_NEXT(a_round_end, clk, rst, (state == S_ROUND && step == 6'd63), (state == S_WBACK))
  `ASSERT_NEXT(a_msg_restart, clk, rst, (out_accept && last_word),
               (msg_ready && fill == 6'd0 && total == 61'd0))
  `ASSERT_IMPL(a_load_bound, clk, rst, (state == S_LOAD), (step <= 6'd16))

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the SHA-256 stream hasher: byte stream in, digest words out.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 210;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int LEN_OFFSET = 56;
  localparam int BOUNDARY_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_ready;
  logic [7:0]  msg_byte = 8'd0;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_stream_hasher dut (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .msg_byte       (msg_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  byte_req_t   pending_reqs [$];
  digest_rec_t digest_expected [$];

  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [60:0] byte_count;

  int          requests_total;
  int          requests_taken;
  int          messages_done;
  int          bytes_hashed;
  int          words_checked;
  int          mismatch_count;
  int          input_stall_cycles;
  int          cycle_count;
  logic        offer_taken;
  int          gap_left;
  int          burst_left;
  byte_req_t   cur_req;
  digest_rec_t head_digest;
  logic        hold_done;
  int          hold_left;
  ready_mode_t ready_mode;
  int          ready_mode_left;
  int          ready_phase;
  logic        next_ready;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_digest();
    int i;
    for (i = 0; i < 8; i++) chain[i] = SHA_IV[i];
    for (i = 0; i < 64; i++) blk[i] = 8'd0;
    fill = 0;
    byte_count = '0;
  endtask

  task automatic compress_into_chain();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    int i;
    for (i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic hash_request(input byte_req_t req);
    logic [63:0] bit_len;
    int i;
    if (req.present) begin
      blk[fill] = req.data;
      fill++;
      byte_count = byte_count + 61'd1;
      bytes_hashed++;
      if (fill == 64) begin
        compress_into_chain();
        fill = 0;
      end
    end
    if (req.eom) begin
      bit_len = {byte_count, 3'b000};
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > LEN_OFFSET) begin
        for (i = fill; i < 64; i++) blk[i] = 8'd0;
        compress_into_chain();
        fill = 0;
      end
      for (i = fill; i < LEN_OFFSET; i++) blk[i] = 8'd0;
      for (i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
      compress_into_chain();
      for (i = 0; i < 8; i++) digest_expected.push_back('{chain[i], i[2:0], i == 7});
      messages_done++;
      restart_digest();
    end
  endtask

  task automatic push_req(input logic [7:0] d, input logic p, input logic e);
    pending_reqs.push_back('{d, p, e});
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests taken, %0d words outstanding",
               cycle_count, requests_taken, requests_total, digest_expected.size());
      $display("tb: failure");
      $finish;
    end
  end

  // driver: bursts of requests with random gaps
  always @(negedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (!msg_valid || offer_taken) begin
      offer_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        msg_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        msg_valid <= 1'b1;
        msg_byte <= cur_req.data;
        byte_present <= cur_req.present;
        end_of_message <= cur_req.eom;
        if (burst_left <= 1) begin
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
        end else begin
          burst_left--;
        end
      end else begin
        msg_valid <= 1'b0;
      end
    end
  end

  // receiver: changing ready pattern, plus one long hold-off while a digest waits
  always @(negedge clk) begin
    if (rst) begin
      digest_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      digest_ready <= 1'b0;
    end else if (!hold_done && requests_taken > 90 && digest_expected.size() > 0) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      digest_ready <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        ready_mode_left = $urandom_range(16, 120);
      end else begin
        ready_mode_left--;
      end
      ready_phase++;
      case (ready_mode)
        RDY_ALWAYS: next_ready = 1'b1;
        RDY_COIN:   next_ready = 1'($urandom_range(0, 1));
        RDY_SPARSE: next_ready = (ready_phase % 4) == 0;
        default:    next_ready = $urandom_range(0, 7) != 0;
      endcase
      digest_ready <= next_ready;
    end
  end

  // monitor: check digest words, then predict from accepted requests
  always @(posedge clk) begin
    if (!rst) begin
      if (digest_valid && digest_ready) begin
        words_checked++;
        if (digest_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected digest word %08h index %0d last %0b",
                     digest_word, word_index, last_word);
        end else begin
          head_digest = digest_expected.pop_front();
          if (digest_word !== head_digest.word || word_index !== head_digest.idx ||
              last_word !== head_digest.is_last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                       head_digest.word, head_digest.idx, head_digest.is_last,
                       digest_word, word_index, last_word);
          end
        end
      end
      if (msg_valid && msg_ready) begin
        hash_request('{msg_byte, byte_present, end_of_message});
        offer_taken = 1'b1;
        requests_taken++;
      end else if (msg_valid) begin
        input_stall_cycles++;
      end
    end
  end

  initial begin
    int len;
    int pick;
    int k;
    logic sep_eom;
    restart_digest();
    offer_taken = 1'b0;
    gap_left = 0;
    burst_left = 8;
    hold_done = 1'b0;
    hold_left = 0;
    ready_mode = RDY_ALWAYS;
    ready_mode_left = 0;
    ready_phase = 0;

    // empty message, then "abc"
    push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    push_req(8'h61, 1'b1, 1'b0);
    push_req(8'h62, 1'b1, 1'b0);
    push_req(8'h63, 1'b1, 1'b1);
    // extremes, an empty item mid-message, a byte-less ending
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'hff, 1'b0, 1'b0);
    push_req(8'hff, 1'b1, 1'b0);
    push_req(8'h5a, 1'b0, 1'b1);
    push_req(8'hff, 1'b1, 1'b1);
    push_req(8'h00, 1'b0, 1'b1);
    push_req(8'ha5, 1'b0, 1'b0);
    push_req(8'h00, 1'b1, 1'b1);

    while (pending_reqs.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) len = 0;
      else if (pick <= 2) len = BOUNDARY_LEN[$urandom_range(0, 9)];
      else if (pick == 3) len = $urandom_range(65, 140);
      else len = $urandom_range(1, 40);
      if (len > RANDOM_ITEMS - pending_reqs.size()) len = RANDOM_ITEMS - pending_reqs.size();
      sep_eom = (len == 0) || ($urandom_range(0, 1) == 1);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_req(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !sep_eom);
      end
      if (sep_eom) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    requests_total = pending_reqs.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (requests_taken == requests_total);
    wait (digest_expected.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests (%0d bytes) through %0d messages, boundary lengths included",
             requests_total, bytes_hashed, messages_done);
    $display("checked %0d digest words, input stalled %0d cycles, %0d mismatches",
             words_checked, input_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && digest_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/sha256_pkg.sv
hdl/sha256_stream_hasher.sv
verif/tb_top.sv
